/* src/spm_pkg.sv */
package spm_pkg;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_SETUP = 3'd1,
        PH_LOW   = 3'd2,
        PH_HIGH  = 3'd3,
        PH_HOLD  = 3'd4,
        PH_GAP   = 3'd5,
        PH_STALL = 3'd6
    } phase_t;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_OFFER = 1'b1
    } op_kind_t;

    // Register indexes on the configuration channel.
    localparam logic [7:0] REG_HALF_BIT = 8'd0;
    localparam logic [7:0] REG_CS_GUARD = 8'd1;

    localparam logic [15:0] HALF_BIT_RESET = 16'd1;
    localparam logic [15:0] CS_GUARD_RESET = 16'd40;
    localparam logic [2:0]  BIT_MSB        = 3'd7;

    typedef struct packed {
        op_kind_t    kind;
        logic [7:0]  tx_byte;
        logic        last_byte;
        logic        miso;
    } op_t;

    typedef struct packed {
        logic        cs_n;
        logic        sck;
        logic        mosi;
        logic        rx_valid;
        logic [7:0]  rx_byte;
        logic        byte_accepted;
        logic        byte_refused;
        logic        frame_done;
        logic        busy_res;
    } res_t;

    typedef struct packed {
        logic        valid;
        logic        full;
    } q_status_t;

endpackage

/* src/spm_ifs.sv */
interface spm_in_if;
    import spm_pkg::*;
    logic        valid;
    logic        ready;
    logic        func;
    logic [7:0]  tx_byte;
    logic        last_byte;
    logic        miso;

    modport source (output valid, output func, output tx_byte, output last_byte,
                    output miso, input ready);
    modport sink   (input valid, input func, input tx_byte, input last_byte,
                    input miso, output ready);
endinterface

interface spm_out_if;
    logic        valid;
    logic        ready;
    logic        cs_n;
    logic        sck;
    logic        mosi;
    logic        rx_valid;
    logic [7:0]  rx_byte;
    logic        byte_accepted;
    logic        byte_refused;
    logic        frame_done;
    logic        busy_res;

    modport source (output valid, output cs_n, output sck, output mosi,
                    output rx_valid, output rx_byte, output byte_accepted,
                    output byte_refused, output frame_done, output busy_res,
                    input ready);
    modport sink   (input valid, input cs_n, input sck, input mosi,
                    input rx_valid, input rx_byte, input byte_accepted,
                    input byte_refused, input frame_done, input busy_res,
                    output ready);
endinterface

interface spm_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/spm_front.sv */
module spm_front
    import spm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    spm_in_if.sink     in_ch,
    input  logic       q_full,
    output logic       push,
    output op_t        push_op
);

    logic stage_valid_reg;
    logic stage_valid_next;
    op_t  stage_reg;
    logic accept;

    assign push         = stage_valid_reg && !q_full;
    assign push_op      = stage_reg;
    assign in_ch.ready  = !stage_valid_reg || !q_full;
    assign accept       = in_ch.valid && in_ch.ready;

    always_comb
    begin
        if (accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (push)
        begin
            stage_valid_next = 1'b0;
        end
        else
        begin
            stage_valid_next = stage_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    // Classify the transaction; fields that the kind does not use are cleared.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg.kind      <= in_ch.func ? OP_OFFER : OP_TICK;
            stage_reg.tx_byte   <= in_ch.func ? in_ch.tx_byte : 8'd0;
            stage_reg.last_byte <= in_ch.func ? in_ch.last_byte : 1'b0;
            stage_reg.miso      <= in_ch.func ? 1'b0 : in_ch.miso;
        end
    end

endmodule

/* src/spm_queue.sv */
module spm_queue
    import spm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  op_t        push_op,
    input  logic       pop,
    output op_t        head_op,
    output q_status_t  status
);

    op_t        entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign head_op      = entry_reg[rd_ptr_reg];
    assign status.valid = count_reg != 2'd0;
    assign status.full  = count_reg == 2'd2;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

/* src/spm_engine.sv */
module spm_engine
    import spm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  op_t        head_op,
    input  q_status_t  q_status,
    output logic       pop,
    spm_cfg_if.sink    cfg_ch,
    spm_out_if.source  out_ch
);

    logic [15:0] half_bit_reg;
    logic [15:0] cs_guard_reg;

    phase_t      phase_reg,       phase_next;
    logic [15:0] timer_reg,       timer_next;
    logic [2:0]  bit_index_reg,   bit_index_next;
    logic [7:0]  send_shift_reg,  send_shift_next;
    logic [7:0]  recv_shift_reg,  recv_shift_next;
    logic        cur_last_reg,    cur_last_next;
    logic [7:0]  held_byte_reg,   held_byte_next;
    logic        held_valid_reg,  held_valid_next;
    logic        held_last_reg,   held_last_next;
    logic        out_valid_reg,   out_valid_next;
    res_t        res_reg,         res_next;

    logic [15:0] phase_len;
    logic [15:0] len_eff;
    logic [16:0] timer_inc;
    logic        tick_end;
    logic        do_load;

    assign cfg_ch.ready = 1'b1;
    assign pop          = q_status.valid && (!out_valid_reg || out_ch.ready);

    // Setup, hold and gap use the guard count; both halves use the half-bit count.
    always_comb
    begin
        if (phase_reg == PH_LOW || phase_reg == PH_HIGH)
        begin
            phase_len = half_bit_reg;
        end
        else
        begin
            phase_len = cs_guard_reg;
        end
        len_eff   = (phase_len == 16'd0) ? 16'd1 : phase_len;
        timer_inc = {1'b0, timer_reg} + 17'd1;
        tick_end  = timer_inc >= {1'b0, len_eff};
    end

    always_comb
    begin
        phase_next      = phase_reg;
        timer_next      = timer_reg;
        bit_index_next  = bit_index_reg;
        send_shift_next = send_shift_reg;
        recv_shift_next = recv_shift_reg;
        cur_last_next   = cur_last_reg;
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        held_last_next  = held_last_reg;
        do_load         = 1'b0;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;

        if (pop)
        begin
            out_valid_next         = 1'b1;
            res_next               = '0;
            if (head_op.kind == OP_OFFER)
            begin
                if (!held_valid_reg)
                begin
                    held_byte_next         = head_op.tx_byte;
                    held_last_next         = head_op.last_byte;
                    held_valid_next        = 1'b1;
                    res_next.byte_accepted = 1'b1;
                end
                else
                begin
                    res_next.byte_refused = 1'b1;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_IDLE:
                    begin
                        if (held_valid_reg)
                        begin
                            do_load    = 1'b1;
                            phase_next = PH_SETUP;
                        end
                    end
                    PH_SETUP:
                    begin
                        timer_next = tick_end ? 16'd0 : timer_inc[15:0];
                        if (tick_end)
                        begin
                            phase_next = PH_LOW;
                        end
                    end
                    PH_LOW:
                    begin
                        timer_next = tick_end ? 16'd0 : timer_inc[15:0];
                        if (tick_end)
                        begin
                            phase_next = PH_HIGH;
                        end
                    end
                    PH_HIGH:
                    begin
                        timer_next = tick_end ? 16'd0 : timer_inc[15:0];
                        if (tick_end)
                        begin
                            recv_shift_next = {recv_shift_reg[6:0], head_op.miso};
                            if (bit_index_reg == 3'd0)
                            begin
                                res_next.rx_valid = 1'b1;
                                res_next.rx_byte  = {recv_shift_reg[6:0], head_op.miso};
                                if (cur_last_reg)
                                begin
                                    phase_next = PH_HOLD;
                                end
                                else if (held_valid_reg)
                                begin
                                    do_load    = 1'b1;
                                    phase_next = PH_LOW;
                                end
                                else
                                begin
                                    phase_next = PH_STALL;
                                end
                            end
                            else
                            begin
                                bit_index_next = bit_index_reg - 3'd1;
                                phase_next     = PH_LOW;
                            end
                        end
                    end
                    PH_STALL:
                    begin
                        if (held_valid_reg)
                        begin
                            do_load    = 1'b1;
                            phase_next = PH_LOW;
                        end
                    end
                    PH_HOLD:
                    begin
                        timer_next = tick_end ? 16'd0 : timer_inc[15:0];
                        if (tick_end)
                        begin
                            phase_next = PH_GAP;
                        end
                    end
                    PH_GAP:
                    begin
                        timer_next = tick_end ? 16'd0 : timer_inc[15:0];
                        if (tick_end)
                        begin
                            phase_next          = PH_IDLE;
                            res_next.frame_done = 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                        timer_next = 16'd0;
                    end
                endcase

                if (do_load)
                begin
                    send_shift_next = held_byte_reg;
                    cur_last_next   = held_last_reg;
                    held_valid_next = 1'b0;
                    bit_index_next  = BIT_MSB;
                    recv_shift_next = 8'd0;
                    timer_next      = 16'd0;
                end
            end

            res_next.cs_n     = (phase_next == PH_IDLE) || (phase_next == PH_GAP);
            res_next.sck      = phase_next == PH_HIGH;
            res_next.mosi     = ((phase_next == PH_LOW) || (phase_next == PH_HIGH)) &&
                                send_shift_next[bit_index_next];
            res_next.busy_res = phase_next != PH_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_bit_reg   <= HALF_BIT_RESET;
            cs_guard_reg   <= CS_GUARD_RESET;
            phase_reg      <= PH_IDLE;
            timer_reg      <= 16'd0;
            bit_index_reg  <= BIT_MSB;
            send_shift_reg <= 8'd0;
            recv_shift_reg <= 8'd0;
            cur_last_reg   <= 1'b0;
            held_valid_reg <= 1'b0;
            held_last_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_ch.valid && cfg_ch.index == REG_HALF_BIT)
            begin
                half_bit_reg <= cfg_ch.data;
            end
            if (cfg_ch.valid && cfg_ch.index == REG_CS_GUARD)
            begin
                cs_guard_reg <= cfg_ch.data;
            end
            phase_reg      <= phase_next;
            timer_reg      <= timer_next;
            bit_index_reg  <= bit_index_next;
            send_shift_reg <= send_shift_next;
            recv_shift_reg <= recv_shift_next;
            cur_last_reg   <= cur_last_next;
            held_valid_reg <= held_valid_next;
            held_last_reg  <= held_last_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_byte_reg <= held_byte_next;
        res_reg       <= res_next;
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.cs_n          = res_reg.cs_n;
    assign out_ch.sck           = res_reg.sck;
    assign out_ch.mosi          = res_reg.mosi;
    assign out_ch.rx_valid      = res_reg.rx_valid;
    assign out_ch.rx_byte       = res_reg.rx_byte;
    assign out_ch.byte_accepted = res_reg.byte_accepted;
    assign out_ch.byte_refused  = res_reg.byte_refused;
    assign out_ch.frame_done    = res_reg.frame_done;
    assign out_ch.busy_res      = res_reg.busy_res;

endmodule

/* src/spi_master_mode0_burst.sv */
// SPI mode 0 burst master driven by a stream of transactions: each input
// transaction is either one timing tick with the sampled MISO level or an offer
// of a byte (with an end-of-frame flag) for the one-byte holding register, and
// each one yields exactly one result with the line levels after it, the
// received byte when its eighth bit completes, the offer outcome and the
// frame status. One transaction is accepted per clock while the result
// channel keeps up; an accepted transaction is registered in the input stage,
// then in the two-entry queue, then in the result register of the phase
// sequencer, which sets the rate.
// Configuration writes are always accepted and should be issued only while
// no transaction is in flight.
module spi_master_mode0_burst
    import spm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    spm_in_if.sink      in_ch,
    spm_cfg_if.sink     cfg_ch,
    spm_out_if.source   out_ch
);

    logic      push;
    op_t       push_op;
    logic      pop;
    op_t       head_op;
    q_status_t q_status;

    spm_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .q_full  (q_status.full),
        .push    (push),
        .push_op (push_op)
    );

    spm_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head_op (head_op),
        .status  (q_status)
    );

    spm_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_op  (head_op),
        .q_status (q_status),
        .pop      (pop),
        .cfg_ch   (cfg_ch),
        .out_ch   (out_ch)
    );

    // A byte completes only on a tick, never on an offer.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.rx_valid |-> !out_ch.byte_accepted && !out_ch.byte_refused)
        else $error("received byte reported on an offer");

    // The end of a frame leaves the block idle with chip select released.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.frame_done |-> out_ch.cs_n && !out_ch.busy_res && !out_ch.sck)
        else $error("frame done while still active");

    // The serial clock runs only inside a frame with chip select asserted.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.sck |-> !out_ch.cs_n && out_ch.busy_res)
        else $error("sck high outside a frame");

    // The queue is never pushed while full.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_status.full |-> !push || pop)
        else $error("queue overflow");

endmodule
